>>> sv/snow_pkg.sv
package snow_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic init_round;
        logic step;
        logic key_lo;
        logic key_hi;
    } cmd_t;

    localparam int unsigned INIT_ROUNDS = 16;
    localparam logic [15:0] POLY_A = 16'h4a6d;
    localparam logic [15:0] POLY_B = 16'hcc87;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] lane_mul_x(input logic [127:0] x, input logic [15:0] poly);
        logic [127:0] r;
        for (int i = 0; i < 8; i++) begin
            r[16*i +: 16] = {x[16*i +: 15], 1'b0} ^ (x[16*i+15] ? poly : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [127:0] add32x4(input logic [127:0] a, input logic [127:0] b);
        logic [127:0] r;
        for (int i = 0; i < 4; i++) begin
            r[32*i +: 32] = a[32*i +: 32] + b[32*i +: 32];
        end
        return r;
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k);
        logic [7:0] t [16];
        logic [7:0] all;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4*c] = SBOX[s[8*(r + 4*((c + r) % 4)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int r = 0; r < 4; r++) begin
                o[8*(4*c + r) +: 8] = t[4*c+r] ^ all ^ xtime(t[4*c+r] ^ t[4*c + ((r + 1) % 4)]);
            end
        end
        return o ^ k;
    endfunction

    function automatic logic [127:0] sigma(input logic [127:0] s);
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            o[8*i +: 8] = s[8*(4*(i % 4) + i / 4) +: 8];
        end
        return o;
    endfunction

endpackage

>>> sv/snow_ctrl.sv
module snow_ctrl
    import snow_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic op,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = op ? ST_OUT : ST_INIT;
                    cnt_next   = '0;
                end
            end
            ST_INIT:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(INIT_ROUNDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = in_valid ? (op ? ST_OUT : ST_INIT) : ST_IDLE;
                    cnt_next   = '0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_INIT:
            begin
                cmd.init_round = 1'b1;
                cmd.key_lo     = (cnt_reg == 4'(INIT_ROUNDS - 2));
                cmd.key_hi     = (cnt_reg == 4'(INIT_ROUNDS - 1));
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default: ;
        endcase
        cmd.load = in_valid && in_ready && !op;
        cmd.step = in_valid && in_ready && op;
    end

endmodule

>>> sv/snow_dp.sv
module snow_dp
    import snow_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [255:0]  key,
    input  logic [127:0]  iv,
    input  cmd_t          cmd,
    input  logic [127:0]  text,
    input  logic          final_block,
    output logic [127:0]  result,
    output logic          final_block_out
);

    logic [255:0] a_reg, b_reg;
    logic [127:0] r1_reg, r2_reg, r3_reg;
    logic [127:0] a0, a1, b0, b1, tap, na, nb, z, t2, r1n;
    logic [127:0] res_reg;
    logic         fin_reg;

    always_comb
    begin
        a0  = a_reg[127:0];
        a1  = a_reg[255:128];
        b0  = b_reg[127:0];
        b1  = b_reg[255:128];
        tap = {a1[111:0], a0[127:112]};
        na  = tap ^ b0 ^ lane_mul_x(a0, POLY_A);
        nb  = b1 ^ a0 ^ lane_mul_x(b0, POLY_B);
        z   = add32x4(b1, r1_reg) ^ r2_reg;
        if (cmd.init_round)
        begin
            na = na ^ z;
        end
        t2  = add32x4(r2_reg, r3_reg);
        r1n = sigma(t2);
        if (cmd.key_lo)
        begin
            r1n = r1n ^ key[127:0];
        end
        if (cmd.key_hi)
        begin
            r1n = r1n ^ key[255:128];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            b_reg   <= '0;
            r1_reg  <= '0;
            r2_reg  <= '0;
            r3_reg  <= '0;
            res_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                a_reg  <= {key[127:0], iv};
                b_reg  <= {key[255:128], 128'h0};
                r1_reg <= '0;
                r2_reg <= '0;
                r3_reg <= key[127:0];
            end
            else if (cmd.init_round || cmd.step)
            begin
                a_reg  <= {na, a1};
                b_reg  <= {nb, b1};
                r3_reg <= aes_round(r2_reg, na);
                r2_reg <= aes_round(r1_reg, '0);
                r1_reg <= r1n;
            end
            if (cmd.step)
            begin
                res_reg <= z ^ text;
                fin_reg <= final_block;
            end
        end
    end

    assign result          = res_reg;
    assign final_block_out = fin_reg;

endmodule

>>> sv/snow_vi_stream_cipher.sv
// SNOW-Vi keystream engine, one 16-byte block per beat.
// A block beat's result appears the cycle after it is accepted and is held until
// taken; a new beat is accepted in the cycle the result is taken, so one block per
// clock while results are taken. An initialize beat loads the state and then runs
// 16 rounds, one per cycle, and the next beat is accepted once they are done.
// Reset clears control, key, IV and cipher state; a block before any initialize beat
// runs from the all-zero state.
module snow_vi_stream_cipher
    import snow_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic        op,
    input  logic [63:0] text_lo,
    input  logic [63:0] text_hi,
    input  logic        final_block,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [63:0] result_lo,
    output logic [63:0] result_hi,
    output logic        final_block_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]  cfg_reg [6];
    cmd_t         cmd;
    logic [127:0] res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we && cfg_index < 3'd6)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    snow_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid),
        .op        (op),
        .in_ready  (ready),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .cmd       (cmd)
    );

    snow_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .key             ({cfg_reg[3], cfg_reg[2], cfg_reg[1], cfg_reg[0]}),
        .iv              ({cfg_reg[5], cfg_reg[4]}),
        .cmd             (cmd),
        .text            ({text_hi, text_lo}),
        .final_block     (final_block),
        .result          (res),
        .final_block_out (final_block_out)
    );

    assign result_lo = res[63:0];
    assign result_hi = res[127:64];

endmodule

>>> sv/snow_checker.sv
module snow_checker (
    input logic clk,
    input logic rst_n,
    input logic valid,
    input logic ready,
    input logic op,
    input logic result_valid,
    input logic result_ready,
    input logic [63:0] result_lo
);

    a_block_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && op |=> result_valid)
        else $error("block beat gave no result");

    a_init_silent: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !op |=> !result_valid && !ready)
        else $error("initialize beat misbehaved");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_lo))
        else $error("result dropped while stalled");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !ready)
        else $error("input taken while result stalled");

endmodule

bind snow_vi_stream_cipher snow_checker u_chk (.*);

>>> tb/tb_snow_vi_stream_cipher.sv
module tb_snow_vi_stream_cipher;
    import snow_pkg::*;

    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_BLOCK = 1'b1;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_IV_LO  = 3'd4;
    localparam logic [2:0] REG_IV_HI  = 3'd5;
    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    localparam int INIT_SETTLE = 24;

    typedef struct {
        logic        op;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        fin;
    } beat_t;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        fin;
    } cipher_out_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        valid = 1'b0;
    logic        ready;
    logic        op = 1'b0;
    logic [63:0] text_lo = '0;
    logic [63:0] text_hi = '0;
    logic        final_block = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [63:0] result_lo;
    logic [63:0] result_hi;
    logic        final_block_out;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    snow_vi_stream_cipher uut (
        .clk(clk), .rst_n(rst_n),
        .valid(valid), .ready(ready), .op(op), .text_lo(text_lo), .text_hi(text_hi),
        .final_block(final_block),
        .result_valid(result_valid), .result_ready(result_ready),
        .result_lo(result_lo), .result_hi(result_hi), .final_block_out(final_block_out),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    beat_t       pending_beats[$];
    cipher_out_t expected_text[$];
    beat_t       cur_beat;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          errors = 0;
    int          n_inits = 0;
    int          n_blocks = 0;
    int          n_checked = 0;

    logic [63:0]  key_w [4];
    logic [63:0]  iv_w [2];
    logic [127:0] a_low, a_high, b_low, b_high, fsm1, fsm2, fsm3;

    function automatic logic [127:0] lanes_times_x(input logic [127:0] x, input logic [15:0] p);
        logic [127:0] r;
        logic [15:0]  l;
        for (int i = 0; i < 8; i++) begin
            l = x[16*i +: 16];
            r[16*i +: 16] = {l[14:0], 1'b0} ^ (l[15] ? p : 16'h0);
        end
        return r;
    endfunction

    function automatic logic [127:0] sum_words(input logic [127:0] a, input logic [127:0] b);
        logic [127:0] r;
        for (int i = 0; i < 4; i++) begin
            r[32*i +: 32] = a[32*i +: 32] + b[32*i +: 32];
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
    endfunction

    function automatic logic [127:0] aes_enc_round(input logic [127:0] s, input logic [127:0] k);
        logic [7:0]   sb [16];
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[4*c + r] = SBOX[s[8*(r + 4*((c + r) % 4)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a0 = sb[4*c + r];
                a1 = sb[4*c + (r + 1) % 4];
                a2 = sb[4*c + (r + 2) % 4];
                a3 = sb[4*c + (r + 3) % 4];
                o[8*(4*c + r) +: 8] = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
            end
        end
        return o ^ k;
    endfunction

    function automatic logic [127:0] transpose_bytes(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[8*(4*c + r) +: 8] = s[8*(4*r + c) +: 8];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] advance_cipher(input logic init_mode);
        logic [255:0] a_all;
        logic [127:0] tap, na, nb, z, t2;
        a_all = {a_high, a_low};
        tap = a_all[239:112];
        na = tap ^ b_low ^ lanes_times_x(a_low, POLY_A);
        nb = b_high ^ a_low ^ lanes_times_x(b_low, POLY_B);
        z = sum_words(b_high, fsm1) ^ fsm2;
        if (init_mode) begin
            na = na ^ z;
        end
        a_low = a_high;
        a_high = na;
        b_low = b_high;
        b_high = nb;
        t2 = sum_words(fsm2, fsm3);
        fsm3 = aes_enc_round(fsm2, na);
        fsm2 = aes_enc_round(fsm1, '0);
        fsm1 = transpose_bytes(t2);
        return z;
    endfunction

    task automatic predict_beat(input beat_t b);
        logic [127:0] z;
        cipher_out_t  e;
        if (b.op == OP_INIT) begin
            a_low = {iv_w[1], iv_w[0]};
            a_high = {key_w[1], key_w[0]};
            b_low = '0;
            b_high = {key_w[3], key_w[2]};
            fsm1 = '0;
            fsm2 = '0;
            fsm3 = {key_w[1], key_w[0]};
            for (int r = 0; r < 16; r++) begin
                z = advance_cipher(1'b1);
                if (r == 14) fsm1 = fsm1 ^ {key_w[1], key_w[0]};
                if (r == 15) fsm1 = fsm1 ^ {key_w[3], key_w[2]};
            end
            n_inits++;
        end else begin
            z = advance_cipher(1'b0);
            e.lo = z[63:0] ^ b.lo;
            e.hi = z[127:64] ^ b.hi;
            e.fin = b.fin;
            expected_text.push_back(e);
            n_blocks++;
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid <= 1'b0;
        end else begin
            if (valid && ready) begin
                predict_beat(cur_beat);
            end
            if (!valid || ready) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = pending_beats.pop_front();
                    op <= cur_beat.op;
                    text_lo <= cur_beat.lo;
                    text_hi <= cur_beat.hi;
                    final_block <= cur_beat.fin;
                    valid <= 1'b1;
                end else begin
                    valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        cipher_out_t e;
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if (result_valid && result_ready) begin
                if (expected_text.size() == 0) begin
                    $error("result beat with no block outstanding: lo=%h hi=%h", result_lo,
                           result_hi);
                    errors++;
                end else begin
                    e = expected_text.pop_front();
                    n_checked++;
                    if (result_lo !== e.lo) begin
                        $error("result_lo expected %h actual %h", e.lo, result_lo);
                        errors++;
                    end
                    if (result_hi !== e.hi) begin
                        $error("result_hi expected %h actual %h", e.hi, result_hi);
                        errors++;
                    end
                    if (final_block_out !== e.fin) begin
                        $error("final_block_out expected %b actual %b", e.fin, final_block_out);
                        errors++;
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_KEY0:  key_w[0] = val;
            REG_KEY1:  key_w[1] = val;
            REG_KEY2:  key_w[2] = val;
            REG_KEY3:  key_w[3] = val;
            REG_IV_LO: iv_w[0] = val;
            REG_IV_HI: iv_w[1] = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_all_regs(input logic [63:0] k0, input logic [63:0] k1,
                                 input logic [63:0] k2, input logic [63:0] k3,
                                 input logic [63:0] ivl, input logic [63:0] ivh);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_IV_LO, ivl);
        write_reg(REG_IV_HI, ivh);
    endtask

    task automatic queue_beat(input logic o, input logic [63:0] lo, input logic [63:0] hi,
                              input logic fin);
        beat_t b;
        b.op = o;
        b.lo = lo;
        b.hi = hi;
        b.fin = fin;
        pending_beats.push_back(b);
    endtask

    task automatic wait_quiet;
        while (pending_beats.size() > 0 || valid || expected_text.size() > 0) begin
            @(posedge clk);
        end
        repeat (INIT_SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand_word;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int run_len;
        for (int i = 0; i < 4; i++) key_w[i] = '0;
        iv_w[0] = '0;
        iv_w[1] = '0;
        a_low = '0; a_high = '0; b_low = '0; b_high = '0;
        fsm1 = '0; fsm2 = '0; fsm3 = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct = 67;

        @(negedge clk);
        // Blocks before any initialization run from the all-zero state.
        queue_beat(OP_BLOCK, '0, '0, 1'b0);
        queue_beat(OP_BLOCK, '1, '1, 1'b1);
        queue_beat(OP_INIT, '1, '1, 1'b1);
        queue_beat(OP_BLOCK, '0, '1, 1'b0);
        queue_beat(OP_BLOCK, '1, '0, 1'b1);
        queue_beat(OP_BLOCK, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        wait_quiet();

        load_all_regs('1, '1, '1, '1, '1, '1);
        write_reg(REG_SPARE6, 64'h5a5a5a5a5a5a5a5a);
        write_reg(REG_SPARE7, '1);
        @(negedge clk);
        queue_beat(OP_INIT, '0, '0, 1'b0);
        for (int i = 0; i < 6; i++) begin
            queue_beat(OP_BLOCK, rand_word(), rand_word(), i[0]);
        end
        // Back-to-back initializations, the second restarting the sequence.
        queue_beat(OP_INIT, '0, '0, 1'b0);
        queue_beat(OP_INIT, '0, '0, 1'b1);
        queue_beat(OP_BLOCK, '0, '0, 1'b1);
        wait_quiet();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 33 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                if (seg == 3) begin
                    load_all_regs('0, '0, '0, '0, '0, '0);
                end else if (seg == 2 && phase == 1) begin
                    load_all_regs('1, '0, '1, '0, '0, '1);
                end else begin
                    load_all_regs({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom});
                end
                @(negedge clk);
                for (int msg = 0; msg < 5; msg++) begin
                    queue_beat(OP_INIT, rand_word(), rand_word(), 1'($urandom_range(1)));
                    run_len = $urandom_range(38, 1);
                    for (int i = 0; i < run_len; i++) begin
                        queue_beat(OP_BLOCK, rand_word(), rand_word(), i == run_len - 1);
                    end
                    if ($urandom_range(3) == 0) begin
                        queue_beat(1'($urandom_range(1)), rand_word(), rand_word(),
                                   1'($urandom_range(1)));
                    end
                end
                wait_quiet();
            end
        end

        $display("Checked %0d cipher blocks from %0d initializations over fourteen key settings,",
                 n_checked, n_inits);
        $display("with sender and receiver stalls in both ratios and at full rate.");
        if (errors == 0) begin
            $display("snow_vi_stream_cipher regression: pass");
        end else begin
            $display("snow_vi_stream_cipher regression: fail");
        end
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("snow_vi_stream_cipher regression: fail");
        $finish;
    end

endmodule
